>>> hdl/nsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

  // fixed-point format
  localparam int unsigned FracBits = 16;
  localparam int unsigned RadW     = 32;
  localparam int unsigned RootW    = 32;
  localparam int unsigned CapW     = 7;

  // positive radicand shifted left by the fraction bits
  localparam int unsigned ScaledW  = RadW - 1 + FracBits;
  // estimate and quotient width, one bit of headroom over the scaled radicand
  localparam int unsigned EstW     = ScaledW + 1;
  localparam int unsigned DivCntW  = $clog2(ScaledW + 1);

  localparam logic [CapW-1:0] CapReset = CapW'(32);
  localparam logic [CapW-1:0] CapMin   = CapW'(1);
  localparam logic [CapW-1:0] CapMax   = CapW'(64);

  typedef struct packed {
    logic                start;
    logic [ScaledW-1:0]  dividend;
    logic [EstW-1:0]     divisor;
  } nsr_div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [EstW-1:0]     quotient;
  } nsr_div_rsp_t;

endpackage

`default_nettype wire

>>> hdl/nsr_div.sv
`timescale 1ns / 1ps
`default_nettype none

// restoring divider, one quotient bit per cycle
module nsr_div import nsr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire nsr_div_req_t req_i,
  output nsr_div_rsp_t      rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [EstW-1:0]     rem_q, rem_d;
  logic [ScaledW-1:0]  quo_q, quo_d;
  logic [EstW-1:0]     dvs_q, dvs_d;
  logic [EstW:0]       trial;
  logic                fits;

  assign trial = {rem_q, quo_q[ScaledW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(ScaledW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? EstW'(trial - {1'b0, dvs_q}) : trial[EstW-1:0];
      quo_d = {quo_q[ScaledW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o = '{busy: busy_q, done: done_q, quotient: EstW'(quo_q)};

endmodule

`default_nettype wire

>>> hdl/newton_square_root.sv
`timescale 1ns / 1ps
`default_nettype none

// square root of a signed Q16.16 radicand, result in unsigned Q16.16. the
// estimate starts at 1.0 and each Newton step forms q = (n << 16) / r and
// r = (r + q) / 2, until a step leaves r unchanged or the iteration cap is
// reached (then hit_limit is set). zero or negative radicands give root 0 with
// not_positive set. a positive radicand runs each Newton step through the
// bit-serial restoring divider shared by all steps, with an update state after
// each divide and the idle and finish states around the loop.
// one request is worked on at a time; s_axis_tready is high only while idle.
// the result sits in an output register, so the next request can be taken
// while the previous result still waits on m_axis_tready.
module newton_square_root import nsr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // iteration cap register
  input  wire logic             cfg_we_i,
  input  wire logic [CapW-1:0]  cfg_wdata_i,
  // request side
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [RadW-1:0]  s_axis_tdata,   // [31:0] radicand
  // result side
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [RootW-1:0]      m_axis_tdata,   // [31:0] root
  output logic [1:0]            m_axis_tuser    // [0] not_positive, [1] hit_limit
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CapW-1:0]     cfg_cap_q;
  logic [CapW-1:0]     cap_q, cap_d;
  logic [CapW-1:0]     iter_q, iter_d;
  logic [CapW-1:0]     iter_next;
  logic [EstW-1:0]     est_q, est_d;
  logic [ScaledW-1:0]  scaled_q, scaled_d;
  logic                np_q, np_d;
  logic                hl_q, hl_d;

  logic                out_valid_q;
  logic [RootW-1:0]    out_root_q;
  logic                out_np_q;
  logic                out_hl_q;
  logic                out_load;

  logic                in_req;
  logic                rad_pos;
  logic [CapW-1:0]     cap_eff;
  logic [EstW:0]       sum;
  logic [EstW-1:0]     est_new;
  logic [EstW-1:0]     div_by;

  nsr_div_req_t        div_req;
  nsr_div_rsp_t        div_rsp;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign rad_pos       = !s_axis_tdata[RadW-1] && (s_axis_tdata != '0);

  // cap of zero runs one step, anything above 64 runs 64
  always_comb begin
    priority if (cfg_cap_q < CapMin) begin
      cap_eff = CapMin;
    end else if (cfg_cap_q > CapMax) begin
      cap_eff = CapMax;
    end else begin
      cap_eff = cfg_cap_q;
    end
  end

  // newton update, floor((r + q) / 2)
  assign sum       = {1'b0, est_q} + {1'b0, div_rsp.quotient};
  assign est_new   = sum[EstW:1];
  assign iter_next = iter_q + CapW'(1);

  always_comb begin
    state_d  = state_q;
    cap_d    = cap_q;
    iter_d   = iter_q;
    est_d    = est_q;
    scaled_d = scaled_q;
    np_d     = np_q;
    hl_d     = hl_q;
    div_by   = est_q;
    div_req.start = 1'b0;
    out_load = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_req) begin
          if (rad_pos) begin
            scaled_d = {s_axis_tdata[RadW-2:0], {FracBits{1'b0}}};
            est_d    = EstW'(1) << FracBits;
            div_by   = EstW'(1) << FracBits;
            cap_d    = cap_eff;
            iter_d   = '0;
            np_d     = 1'b0;
            hl_d     = 1'b0;
            div_req.start = 1'b1;
            state_d  = ST_DIV;
          end else begin
            est_d   = '0;
            np_d    = 1'b1;
            hl_d    = 1'b0;
            state_d = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        iter_d = iter_next;
        if (est_new == est_q) begin
          hl_d    = 1'b0;
          state_d = ST_FIN;
        end else begin
          est_d = est_new;
          if (iter_next == cap_q) begin
            hl_d    = 1'b1;
            state_d = ST_FIN;
          end else begin
            // zero estimate guard, replaced by one
            div_by = (est_new == '0) ? EstW'(1) : est_new;
            div_req.start = 1'b1;
            state_d = ST_DIV;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    div_req.dividend = (state_q == ST_IDLE) ? scaled_d : scaled_q;
    div_req.divisor  = div_by;
  end

  nsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_cap_q   <= CapReset;
      out_valid_q <= 1'b0;
      iter_q      <= '0;
      cap_q       <= CapReset;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      cap_q   <= cap_d;
      if (cfg_we_i) begin
        cfg_cap_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    est_q    <= est_d;
    scaled_q <= scaled_d;
    np_q     <= np_d;
    hl_q     <= hl_d;
    if (out_load) begin
      out_root_q <= est_q[RootW-1:0];
      out_np_q   <= np_q;
      out_hl_q   <= hl_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_root_q;
  assign m_axis_tuser  = {out_hl_q, out_np_q};

  // divider only runs while a newton step waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == ST_DIV))
    else $error("divider busy outside the divide state");

  // step count never passes the latched cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV || state_q == ST_UPD) |-> (iter_q < cap_q))
    else $error("iteration count at or beyond cap while iterating");

  // a non-positive result carries a zero root and no limit flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("non-positive result with nonzero root or limit flag");

  // a request taken in idle starts a divide or goes straight to the finish state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_DIV || state_q == ST_FIN))
    else $error("accepted request did not start work");

endmodule

`default_nettype wire

>>> verif/newton_square_root_test.sv
`timescale 1ns / 1ps

// tvalid/tready flow test for newton_square_root
module newton_square_root_test;
  import nsr_pkg::*;

  // tuser bit positions on the result side
  localparam int unsigned NotPositiveBit = 0;
  localparam int unsigned HitLimitBit    = 1;

  // longest stretch with no handshake on either side before the run is called dead
  // (long enough to outlast one request at the cap of 64 and the long hold-off)
  localparam int unsigned QuietLimit = 20000;
  // long result-side hold-off, used once in the hold phase
  localparam int unsigned HoldCycles = 4000;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 92;
  localparam int unsigned HoldPhase  = 3;
  localparam int unsigned NumSweep   = 6;

  typedef struct packed {
    logic [RootW-1:0] root;
    logic             not_positive;
    logic             hit_limit;
  } sqrt_result_t;

  typedef struct packed {
    logic [RadW-1:0] radicand;
    logic            known;     // result typed in below, else taken from newton_root
    sqrt_result_t    result;
  } directed_row_t;

  localparam sqrt_result_t NonPositive = '{root: '0, not_positive: 1'b1, hit_limit: 1'b0};
  localparam sqrt_result_t Predicted   = '0;
  localparam int unsigned  NumDirected = 19;

  // directed requests, all at the reset cap of 32
  localparam directed_row_t DirectedRows [NumDirected] = '{
    '{32'h0000_0000, 1'b1, NonPositive},                       // zero
    '{32'hFFFF_FFFF, 1'b1, NonPositive},                       // smallest negative step
    '{32'h8000_0000, 1'b1, NonPositive},                       // most negative
    '{32'hC000_0000, 1'b1, NonPositive},
    '{32'h0001_0000, 1'b1, '{32'h0001_0000, 1'b0, 1'b0}},      // 1.0 settles at once
    '{32'h0000_0001, 1'b0, Predicted},                         // smallest positive
    '{32'h0000_0002, 1'b0, Predicted},
    '{32'h0000_0100, 1'b0, Predicted},
    '{32'h0000_8000, 1'b0, Predicted},                         // 0.5
    '{32'h0002_0000, 1'b0, Predicted},                         // 2.0
    '{32'h0004_0000, 1'b0, Predicted},                         // 4.0
    '{32'h0009_0000, 1'b0, Predicted},                         // 9.0
    '{32'h0000_FFFE, 1'b0, Predicted},                         // two-value oscillation
    '{32'h0000_3FFF, 1'b0, Predicted},                         // two-value oscillation
    '{32'h4000_0000, 1'b0, Predicted},                         // 16384.0
    '{32'h7FFF_0000, 1'b0, Predicted},
    '{32'h7FFF_FFFF, 1'b0, Predicted},                         // largest positive
    '{32'h5555_5555, 1'b0, Predicted},
    '{32'h2AAA_AAAA, 1'b0, Predicted}
  };

  // cap extremes first, the rest random, back to the reset value at the end
  localparam logic [CapW-1:0] CapSweep [NumSweep] = '{
    CapW'(0), CapMin, CapW'(127), CapMax, CapW'(65), CapW'(2)
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CapW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [RadW-1:0]     s_axis_tdata  = '0;   // [31:0] radicand
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [RootW-1:0]    m_axis_tdata;         // [31:0] root
  logic [1:0]          m_axis_tuser;         // [0] not_positive, [1] hit_limit

  // own copy of the cap register, updated on every write
  logic [CapW-1:0]     cap_setting = CapReset;
  sqrt_result_t        pending_roots [$];
  int unsigned         fail_count    = 0;
  int unsigned         quiet_cycles  = 0;
  // idling odds in percent per request / per cycle, zero turns idling off
  int unsigned         gap_odds      = 20;
  int unsigned         stall_odds    = 20;
  bit                  hold_results  = 1'b0;

  newton_square_root i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // babylonian iteration on 64-bit integers, cap clamped to 1..64
  function automatic sqrt_result_t newton_root(input logic [RadW-1:0] radicand,
                                               input logic [CapW-1:0] cap_reg);
    sqrt_result_t res;
    logic [63:0]  scaled;
    logic [63:0]  est;
    logic [63:0]  quot;
    logic [63:0]  next_est;
    int unsigned  steps;
    int unsigned  done_steps;
    bit           settled;
    res = '0;
    if (radicand == '0 || radicand[RadW-1]) begin
      res.not_positive = 1'b1;
      return res;
    end
    steps = 32'(cap_reg);
    if (steps < 32'(CapMin)) steps = 32'(CapMin);
    if (steps > 32'(CapMax)) steps = 32'(CapMax);
    scaled     = 64'(radicand) << FracBits;
    est        = 64'd1 << FracBits;
    done_steps = 0;
    settled    = 1'b0;
    while (done_steps < steps && !settled) begin
      // guard only, a positive radicand never drives the estimate to zero
      if (est == 64'd0) est = 64'd1;
      quot     = scaled / est;
      next_est = (est + quot) >> 1;
      if (next_est == est) begin
        settled = 1'b1;
      end else begin
        est = next_est;
      end
      done_steps++;
    end
    res.root      = est[RootW-1:0];
    res.hit_limit = !settled;
    return res;
  endfunction

  // mix of magnitudes: full random (half negative), small values below 4.0, values that
  // oscillate between two estimates (n << 16 one below a perfect square), powers
  // of two and small negatives
  function automatic logic [RadW-1:0] pick_radicand();
    int unsigned kind;
    int unsigned a;
    kind = $urandom_range(0, 99);
    a    = $urandom_range(1, 361);
    if (kind < 40) return $urandom();
    if (kind < 60) return RadW'($urandom_range(1, 32'h3_FFFF));
    if (kind < 72) begin
      if ($urandom_range(0, 1) == 0) return RadW'(a * a * 16384 - a);
      return RadW'(a * a * 16384 + a);
    end
    if (kind < 85) return RadW'(1) << $urandom_range(0, RadW - 2);
    return -RadW'($urandom_range(0, 4096));
  endfunction

  // offer one request, optionally after a gap, and log its expected result on acceptance
  task automatic send_radicand(input logic [RadW-1:0] radicand, input logic known,
                               input sqrt_result_t known_result);
    int unsigned pause;
    if (gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
      pause = $urandom_range(1, 17);
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= radicand;
    do @(posedge clk_i); while (!s_axis_tready);
    if (known) begin
      pending_roots.push_back(known_result);
    end else begin
      pending_roots.push_back(newton_root(radicand, cap_setting));
    end
  endtask

  // sender pauses until every result is back, then waits for the block to settle
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cap(input logic [CapW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cap_setting = value;
    cfg_we_i    <= 1'b0;
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned burst;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_results = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_odds != 0 && $urandom_range(0, 99) < stall_odds) begin
        burst = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    sqrt_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_roots.size() == 0) begin
        $error("unexpected result: root %h tuser %b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = pending_roots.pop_front();
        if (m_axis_tdata !== want.root) begin
          $error("root: expected %h, got %h", want.root, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[NotPositiveBit] !== want.not_positive) begin
          $error("not_positive: expected %b, got %b", want.not_positive,
                 m_axis_tuser[NotPositiveBit]);
          fail_count++;
        end
        if (m_axis_tuser[HitLimitBit] !== want.hit_limit) begin
          $error("hit_limit: expected %b, got %b", want.hit_limit, m_axis_tuser[HitLimitBit]);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CapW-1:0] cap_value;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset cap
    for (int i = 0; i < NumDirected; i++) begin
      send_radicand(DirectedRows[i].radicand, DirectedRows[i].known, DirectedRows[i].result);
    end
    wait_for_results();

    // random part, one cap setting per phase, block idle at every write
    for (int p = 0; p < NumPhases; p++) begin
      if (p < NumSweep) begin
        cap_value = CapSweep[p];
      end else if (p == NumPhases - 1) begin
        cap_value = CapReset;
      end else begin
        cap_value = CapW'($urandom_range(0, 127));
      end
      write_cap(cap_value);
      if (p == NumPhases - 1) begin
        // closing stretch runs at full rate
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = 20 * $urandom_range(0, 3);
        stall_odds = 20 * $urandom_range(0, 3);
      end
      // hold results long enough for the block to fill up and drop tready
      if (p == HoldPhase) hold_results = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        send_radicand(pick_radicand(), 1'b0, Predicted);
      end
      wait_for_results();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
